### hdl/swdds_pkg.sv
// ----------------------------------------------------------------------------
// swdds_pkg: shared types and constants
// Field widths, register codes and the reciprocal tables used for the
// decimal split of the distance.
// ----------------------------------------------------------------------------
package swdds_pkg;

	localparam int unsigned COUNT_W  = 16;  // wheel count width
	localparam int unsigned SUM_W    = 17;  // left + right
	localparam int unsigned SCALE_W  = 7;
	localparam int unsigned TPS_W    = 16;
	localparam int unsigned CFG_W    = 16;  // widest register
	localparam int unsigned PROD_W   = 24;  // sum * scale, below 2^24
	localparam int unsigned RECIP_W  = 25;  // reciprocal multiplier width
	localparam int unsigned MUL_W    = PROD_W + RECIP_W;
	localparam int unsigned SHIFT_W  = 6;
	localparam int unsigned QUOT_W   = 18;  // product / 100 at most
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned POS_W    = 2;
	localparam int unsigned DIV_N    = 5;   // divisors 10^2 .. 10^6
	localparam int unsigned DIV_IDX_W = 3;

	typedef logic [0:0] cfg_index_t;

	localparam cfg_index_t REG_TICKS_PER_SECOND = 1'b0;
	localparam cfg_index_t REG_DISTANCE_SCALE   = 1'b1;

	localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd1000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd12;

	localparam logic [POS_W-1:0]   POS_UNITS     = 2'd0;
	localparam logic [POS_W-1:0]   POS_TENS      = 2'd1;
	localparam logic [POS_W-1:0]   POS_HUNDREDS  = 2'd2;
	localparam logic [POS_W-1:0]   POS_THOUSANDS = 2'd3;

	localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'hF;
	localparam logic [DIGIT_W-1:0] MAX_DIGIT   = 4'd9;

	// floor(p / d) == (p * m) >> (PROD_W + l), m = ceil(2^(PROD_W+l) / d),
	// l = ceil(log2 d); exact for every p below 2^PROD_W.
	localparam logic [RECIP_W-1:0] RECIP_MUL [DIV_N] = '{
		RECIP_W'(((64'd1 << (PROD_W + 7))  + 64'd99)      / 64'd100),
		RECIP_W'(((64'd1 << (PROD_W + 10)) + 64'd999)     / 64'd1000),
		RECIP_W'(((64'd1 << (PROD_W + 14)) + 64'd9999)    / 64'd10000),
		RECIP_W'(((64'd1 << (PROD_W + 17)) + 64'd99999)   / 64'd100000),
		RECIP_W'(((64'd1 << (PROD_W + 20)) + 64'd999999)  / 64'd1000000)
	};

	localparam logic [SHIFT_W-1:0] RECIP_SHIFT [DIV_N] = '{
		SHIFT_W'(PROD_W + 7),
		SHIFT_W'(PROD_W + 10),
		SHIFT_W'(PROD_W + 14),
		SHIFT_W'(PROD_W + 17),
		SHIFT_W'(PROD_W + 20)
	};

	// scan position and the time digit shown there
	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [DIGIT_W-1:0] digit;
	} clock_view_t;

endpackage

### hdl/swdds_tick_if.sv
// ----------------------------------------------------------------------------
// swdds_tick_if: tick channel
// One transfer per tick, carrying both wheel counts.
// ----------------------------------------------------------------------------
interface swdds_tick_if;
	import swdds_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] left_count;
	logic [COUNT_W-1:0] right_count;

	modport source (output valid, output left_count, output right_count, input ready);
	modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

### hdl/swdds_digit_if.sv
// ----------------------------------------------------------------------------
// swdds_digit_if: digit channel
// One transfer per tick: scan position, time digit and distance digit.
// ----------------------------------------------------------------------------
interface swdds_digit_if;
	import swdds_pkg::*;

	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   digit_position;
	logic [DIGIT_W-1:0] clock_digit;
	logic [DIGIT_W-1:0] distance_digit;

	modport source (output valid, output digit_position, output clock_digit,
		output distance_digit, input ready);
	modport sink   (input valid, input digit_position, input clock_digit,
		input distance_digit, output ready);
endinterface

### hdl/swdds_clock.sv
// ----------------------------------------------------------------------------
// swdds_clock: BCD stopwatch and scan position
// Advances the time counters on each tick, all carries in one go, and
// presents the scan position with the updated time digit there.
// ----------------------------------------------------------------------------
module swdds_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_en,
	input  logic [swdds_pkg::TPS_W-1:0]   ticks_per_second,
	output swdds_pkg::clock_view_t        view
);
	import swdds_pkg::*;

	logic [TPS_W-1:0] sub_q, sub_inc, sub_d;
	logic [3:0]       su_q, su_inc, su_d;
	logic [2:0]       st_q, st_inc, st_d;
	logic [3:0]       mu_q, mu_inc, mu_d;
	logic [3:0]       mt_q, mt_inc, mt_d;
	logic [POS_W-1:0] pos_q;
	logic             c_sub, c_su, c_st, c_mu;

	always_comb begin
		sub_inc = sub_q + 1'b1;
		c_sub   = (sub_inc == ticks_per_second);
		sub_d   = c_sub ? '0 : sub_inc;

		su_inc = su_q + 1'b1;
		c_su   = c_sub && (su_inc >= 4'd10);
		su_d   = c_sub ? (c_su ? 4'd0 : su_inc) : su_q;

		st_inc = st_q + 1'b1;
		c_st   = c_su && (st_inc >= 3'd6);
		st_d   = c_su ? (c_st ? 3'd0 : st_inc) : st_q;

		mu_inc = mu_q + 1'b1;
		c_mu   = c_st && (mu_inc >= 4'd10);
		mu_d   = c_st ? (c_mu ? 4'd0 : mu_inc) : mu_q;

		mt_inc = mt_q + 1'b1;
		mt_d   = c_mu ? ((mt_inc >= 4'd10) ? 4'd0 : mt_inc) : mt_q;
	end

	always_comb begin
		view.position = pos_q;
		case (pos_q)
			POS_UNITS:    view.digit = su_d;
			POS_TENS:     view.digit = {1'b0, st_d};
			POS_HUNDREDS: view.digit = mu_d;
			default:      view.digit = mt_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			su_q  <= '0;
			st_q  <= '0;
			mu_q  <= '0;
			mt_q  <= '0;
			pos_q <= POS_UNITS;
		end else if (tick_en) begin
			sub_q <= sub_d;
			su_q  <= su_d;
			st_q  <= st_d;
			mu_q  <= mu_d;
			mt_q  <= mt_d;
			pos_q <= pos_q + 1'b1;
		end
	end

endmodule

### hdl/stopwatch_distance_digit_scanner.sv
// ----------------------------------------------------------------------------
// stopwatch_distance_digit_scanner: multiplexed stopwatch / distance digits
// Keeps a BCD mm:ss stopwatch and scans four display digits, giving the
// time digit and the wheel distance digit for each scan position.
// ----------------------------------------------------------------------------
// Usage: one tick transfer is taken every clock cycle while the output side
// keeps up, and each tick gives exactly one digit transfer after passing the
// input stage, scale multiply, reciprocal multiply and result register. The
// arithmetic pipeline does, in order: sum of the wheel counts, the
// multiply by the scale register, then a pair of reciprocal multiplies that
// divide the scaled product by 100 * 10^position and by ten times that. The
// stopwatch itself updates in the cycle a tick is taken, so the time digit
// in a result reflects that tick. Backpressure on the digit channel stalls
// the whole pipeline without losing or repeating anything. Write the two
// registers only while no tick is in flight.
// ----------------------------------------------------------------------------
module stopwatch_distance_digit_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  swdds_pkg::cfg_index_t         cfg_index,
	input  logic [swdds_pkg::CFG_W-1:0]   cfg_wdata,
	swdds_tick_if.sink                    tick,
	swdds_digit_if.source                 digit
);
	import swdds_pkg::*;

	// configuration registers
	logic [TPS_W-1:0]   tps_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TICKS_PER_SECOND: tps_q   <= cfg_wdata[TPS_W-1:0];
				REG_DISTANCE_SCALE:   scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: a stage loads when it is empty or its content moves on
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic free_s1, free_s2, free_s3;
	logic take;

	assign free_s3    = !out_valid_q || digit.ready;
	assign free_s2    = !v_s3 || free_s3;
	assign free_s1    = !v_s2 || free_s2;
	assign tick.ready = !v_s1 || free_s1;
	assign take       = tick.valid && tick.ready;

	// stopwatch advances on every tick transfer
	clock_view_t view_now;

	swdds_clock u_clock (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick_en          (take),
		.ticks_per_second (tps_q),
		.view             (view_now)
	);

	// stage 1: summed wheel counts
	logic [SUM_W-1:0]  sum_s1;
	clock_view_t       view_s1;

	// stage 2: scaled product, below 2^24
	logic [PROD_W-1:0] prod_s2;
	clock_view_t       view_s2;

	// stage 3: quotient at this position and the low nibble of the next one
	logic [QUOT_W-1:0]  lo_s3;
	logic [DIGIT_W-1:0] hi_s3;
	clock_view_t        view_s3;

	// result register
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] clkd_q;
	logic [DIGIT_W-1:0] distd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready) v_s1 <= take;
			if (free_s1)    v_s2 <= v_s1;
			if (free_s2)    v_s3 <= v_s2;
			if (free_s3)    out_valid_q <= v_s3;
		end
	end

	// reciprocal division: lo = product / (100 * 10^pos), hi = lo / 10
	logic [DIV_IDX_W-1:0] idx_lo, idx_hi;
	logic [MUL_W-1:0]     mul_lo, mul_hi;
	logic [QUOT_W-1:0]    lo_d;
	logic [DIGIT_W-1:0]   hi_d;

	always_comb begin
		idx_lo = {1'b0, view_s2.position};
		idx_hi = idx_lo + 1'b1;
		mul_lo = MUL_W'(prod_s2) * MUL_W'(RECIP_MUL[idx_lo]);
		mul_hi = MUL_W'(prod_s2) * MUL_W'(RECIP_MUL[idx_hi]);
		lo_d   = QUOT_W'(mul_lo >> RECIP_SHIFT[idx_lo]);
		hi_d   = DIGIT_W'(mul_hi >> RECIP_SHIFT[idx_hi]);
	end

	// digit = lo - 10 * hi, known to be 0..9, so four bits suffice;
	// the thousands digit blanks when the quotient exceeds nine
	logic [DIGIT_W-1:0] dist_digit_d;

	always_comb begin
		if (view_s3.position == POS_THOUSANDS) begin
			dist_digit_d = (lo_s3 > QUOT_W'(MAX_DIGIT)) ? BLANK_DIGIT : lo_s3[DIGIT_W-1:0];
		end else begin
			dist_digit_d = lo_s3[DIGIT_W-1:0] - DIGIT_W'(hi_s3 * 4'd10);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sum_s1  <= SUM_W'(tick.left_count) + SUM_W'(tick.right_count);
			view_s1 <= view_now;
		end
		if (free_s1 && v_s1) begin
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(scale_q);
			view_s2 <= view_s1;
		end
		if (free_s2 && v_s2) begin
			lo_s3   <= lo_d;
			hi_s3   <= hi_d;
			view_s3 <= view_s2;
		end
		if (free_s3 && v_s3) begin
			pos_q   <= view_s3.position;
			clkd_q  <= view_s3.digit;
			distd_q <= dist_digit_d;
		end
	end

	assign digit.valid          = out_valid_q;
	assign digit.digit_position = pos_q;
	assign digit.clock_digit    = clkd_q;
	assign digit.distance_digit = distd_q;

endmodule
